// ===== hw/rtl/d3r_pkg.sv =====
package d3r_pkg;

    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int PIX_W     = 12;
    localparam int DISP_W    = 16;
    localparam int COORD_W   = 32;
    localparam int LANES     = 3;
    // quotient bits: 16 integer, 16 fraction
    localparam int QUO_W     = 2 * FRAC_BITS;

    localparam int DEF_COLUMN_BITS   = 12;
    localparam int DEF_ROW_BITS      = 12;
    localparam int DEF_DISCARD_LIMIT = 10;

    typedef enum logic [IDX_W-1:0] {
        REG_Q_R0C01 = 3'd0,
        REG_Q_R0C23 = 3'd1,
        REG_Q_R1C01 = 3'd2,
        REG_Q_R1C23 = 3'd3,
        REG_Q_R2C01 = 3'd4,
        REG_Q_R2C23 = 3'd5,
        REG_Q_R3C01 = 3'd6,
        REG_Q_R3C23 = 3'd7
    } reg_idx_t;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic [PIX_W-1:0]         pixel_column;
        logic [PIX_W-1:0]         pixel_row;
        logic signed [DISP_W-1:0] disparity_value;
    } pixel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [LANES-1:0] neg;
    } d3r_ctrl_t;

    // signed width of one vector element (16x, 16y, d, 16)
    function automatic int vec_width(input int cb, input int rb);
        int w;
        w = ((cb > rb) ? cb : rb) + 5;
        return (w > DISP_W) ? w : DISP_W;
    endfunction

endpackage

// ===== hw/rtl/d3r_matmul.sv =====
module d3r_matmul
    import d3r_pkg::*;
#(
    parameter int COLUMN_BITS = DEF_COLUMN_BITS,
    parameter int ROW_BITS    = DEF_ROW_BITS,
    localparam int VEC_W      = vec_width(COLUMN_BITS, ROW_BITS),
    localparam int PROD_W     = COEF_W + VEC_W,
    localparam int SUM_W      = PROD_W + 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  pixel_t                   pix,
    input  logic signed [COEF_W-1:0] coef [4][4],
    output d3r_ctrl_t                ctrl,
    output logic [SUM_W-1:0]         num_mag [LANES],
    output logic [SUM_W-1:0]         den_mag
);

    localparam int EXT_W = 16;
    localparam int CMP_W = SUM_W + FRAC_BITS;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    logic [EXT_W-1:0] x_ext, y_ext;
    vec_t             vec [4];

    logic  valid_a_reg, valid_p_reg, valid_s1_reg, valid_s2_reg;
    vec_t  vec_reg [4];
    prod_t prod_reg [4][4];
    logic signed [PROD_W:0] pair_reg [4][2];
    sum_t  sum_reg [4];

    d3r_ctrl_t        ctrl_next, ctrl_reg;
    logic [SUM_W-1:0] mag_next [4];
    logic [SUM_W-1:0] num_reg [LANES];
    logic [SUM_W-1:0] den_reg;
    logic             in_range;

    // bits above the configured widths are ignored
    assign x_ext = EXT_W'(pix.pixel_column) & EXT_W'((32'd1 << COLUMN_BITS) - 32'd1);
    assign y_ext = EXT_W'(pix.pixel_row) & EXT_W'((32'd1 << ROW_BITS) - 32'd1);
    assign vec[0] = vec_t'({x_ext, 4'b0000});
    assign vec[1] = vec_t'({y_ext, 4'b0000});
    assign vec[2] = vec_t'(pix.disparity_value);
    assign vec[3] = vec_t'(16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg  <= 1'b0;
            valid_p_reg  <= 1'b0;
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            ctrl_reg     <= '0;
        end
        else
        begin
            valid_a_reg  <= in_valid && (pix.disparity_value != '0);
            valid_p_reg  <= valid_a_reg;
            valid_s1_reg <= valid_p_reg;
            valid_s2_reg <= valid_s1_reg;
            ctrl_reg     <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            vec_reg[c] <= vec[c];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[r][c] <= prod_t'(coef[r][c]) * prod_t'(vec_reg[c]);
            end
            pair_reg[r][0] <= (PROD_W+1)'(prod_reg[r][0]) + (PROD_W+1)'(prod_reg[r][1]);
            pair_reg[r][1] <= (PROD_W+1)'(prod_reg[r][2]) + (PROD_W+1)'(prod_reg[r][3]);
            sum_reg[r]     <= sum_t'(pair_reg[r][0]) + sum_t'(pair_reg[r][1]);
        end
        for (int l = 0; l < LANES; l++)
        begin
            num_reg[l] <= mag_next[l];
        end
        den_reg <= mag_next[3];
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mag_next[r] = sum_reg[r][SUM_W-1] ? SUM_W'(-sum_reg[r]) : SUM_W'(sum_reg[r]);
        end
        // a quotient of 2^16 or more is far beyond any limit
        in_range = 1'b1;
        for (int l = 0; l < LANES; l++)
        begin
            if (CMP_W'(mag_next[l]) >= (CMP_W'(mag_next[3]) << FRAC_BITS))
            begin
                in_range = 1'b0;
            end
            ctrl_next.neg[l] = sum_reg[l][SUM_W-1] ^ sum_reg[3][SUM_W-1];
        end
        ctrl_next.valid = valid_s2_reg;
        ctrl_next.ok    = (mag_next[3] != '0) && in_range;
    end

    assign ctrl    = ctrl_reg;
    assign num_mag = num_reg;
    assign den_mag = den_reg;

endmodule

// ===== hw/rtl/d3r_div_cell.sv =====
module d3r_div_cell
    import d3r_pkg::*;
#(
    parameter int REM_W = 72
)
(
    input  logic             clk,
    input  logic [REM_W-1:0] rem_in,
    input  logic [REM_W-1:0] dsh_in,
    input  logic [QUO_W-1:0] quo_in,
    output logic [REM_W-1:0] rem_out,
    output logic [REM_W-1:0] dsh_out,
    output logic [QUO_W-1:0] quo_out
);

    logic             fits;
    logic [REM_W-1:0] rem_sub;
    logic [REM_W-1:0] rem_reg, dsh_reg;
    logic [QUO_W-1:0] quo_reg;

    // restoring step; remainder stays below twice the shifted divisor
    assign fits    = rem_in >= dsh_in;
    assign rem_sub = fits ? (rem_in - dsh_in) : rem_in;

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_sub << 1;
        dsh_reg <= dsh_in;
        quo_reg <= {quo_in[QUO_W-2:0], fits};
    end

    assign rem_out = rem_reg;
    assign dsh_out = dsh_reg;
    assign quo_out = quo_reg;

endmodule

// ===== hw/rtl/disparity_to_3d_reprojection_top.sv =====
// Stereo disparity to 3D point reprojection.
// Input: assert start with in (column, row, Q12.4 disparity). busy is always
// low, so an item is taken on every cycle that start is high.
// The vector (16x, 16y, d, 16) is multiplied by the 4x4 Q16.16 matrix held in
// eight 64-bit registers, written by the user through cfg_wr_en / cfg_index /
// cfg_data while no item is in flight; the block does not enforce this.
// Output: result_valid is high for one cycle with result (X, Y, Z in Q16.16,
// rounded toward zero). Items with zero disparity, zero fourth sum, or any
// coordinate beyond DISCARD_LIMIT give no result; kept results stay in order.
// From accept to the result strobe an item passes one input register,
// products, two adder levels, magnitude/sign, 32 divider cells (one quotient
// bit each, three lanes side by side) and the output register.
// Throughput is one item per clock. Reset loads the identity matrix.
// There is no back-pressure: the receiver must take each result as it comes.
// Reset empties the pipeline; items in flight are dropped.
module disparity_to_3d_reprojection_top
    import d3r_pkg::*;
#(
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS,
    parameter int ROW_BITS      = DEF_ROW_BITS,
    parameter int DISCARD_LIMIT = DEF_DISCARD_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pixel_t           in,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    output logic             result_valid,
    output point_t           result
);

    localparam int VEC_W   = vec_width(COLUMN_BITS, ROW_BITS);
    localparam int SUM_W   = COEF_W + VEC_W + 2;
    localparam int REM_W   = SUM_W + FRAC_BITS + 1;
    localparam int NCELL   = QUO_W;
    localparam int LATENCY = NCELL + 6;
    localparam logic [FRAC_BITS-1:0] LIMIT = FRAC_BITS'(DISCARD_LIMIT);
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

    logic [REG_W-1:0]         q_reg [NUM_REGS];
    logic signed [COEF_W-1:0] coef [4][4];

    d3r_ctrl_t        mm_ctrl;
    logic [SUM_W-1:0] num_mag [LANES];
    logic [SUM_W-1:0] den_mag;

    logic [REM_W-1:0] rem_w [LANES][NCELL+1];
    logic [REM_W-1:0] dsh_w [LANES][NCELL+1];
    logic [QUO_W-1:0] quo_w [LANES][NCELL+1];

    d3r_ctrl_t ctrl_reg [NCELL];
    d3r_ctrl_t ctrl_end;

    logic             over;
    logic [QUO_W-1:0] m;
    point_t           result_next, result_reg;
    logic             result_valid_reg;
    logic [COORD_W-1:0] coord [LANES];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                q_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_wr_en)
        begin
            q_reg[cfg_index] <= cfg_data;
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            if ((c % 2) == 0)
            begin : g_hi
                assign coef[r][c] = q_reg[2*r + c/2][REG_W-1:COEF_W];
            end
            else
            begin : g_lo
                assign coef[r][c] = q_reg[2*r + c/2][COEF_W-1:0];
            end
        end
    end

    d3r_matmul #(
        .COLUMN_BITS (COLUMN_BITS),
        .ROW_BITS    (ROW_BITS)
    ) u_matmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .pix      (in),
        .coef     (coef),
        .ctrl     (mm_ctrl),
        .num_mag  (num_mag),
        .den_mag  (den_mag)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign rem_w[l][0] = REM_W'(num_mag[l]);
        assign dsh_w[l][0] = REM_W'(den_mag) << (FRAC_BITS - 1);
        assign quo_w[l][0] = '0;
        for (genvar k = 0; k < NCELL; k++)
        begin : g_cell
            d3r_div_cell #(
                .REM_W (REM_W)
            ) u_cell (
                .clk     (clk),
                .rem_in  (rem_w[l][k]),
                .dsh_in  (dsh_w[l][k]),
                .quo_in  (quo_w[l][k]),
                .rem_out (rem_w[l][k+1]),
                .dsh_out (dsh_w[l][k+1]),
                .quo_out (quo_w[l][k+1])
            );
        end
    end

    // control travels beside the divider cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCELL; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else
        begin
            ctrl_reg[0] <= mm_ctrl;
            for (int k = 1; k < NCELL; k++)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    assign ctrl_end = ctrl_reg[NCELL-1];

    always_comb
    begin
        over = 1'b0;
        m    = '0;
        for (int l = 0; l < LANES; l++)
        begin
            m = quo_w[l][NCELL];
            if ((m[QUO_W-1:FRAC_BITS] > LIMIT) ||
                ((m[QUO_W-1:FRAC_BITS] == LIMIT) &&
                 ((m[FRAC_BITS-1:0] != '0) || (rem_w[l][NCELL] != '0))))
            begin
                over = 1'b1;
            end
            if (ctrl_end.neg[l])
            begin
                coord[l] = (m > NEG_MAX) ? NEG_MAX : COORD_W'(-m);
            end
            else
            begin
                coord[l] = (m > POS_MAX) ? POS_MAX : COORD_W'(m);
            end
        end
        result_next.point_x = coord[0];
        result_next.point_y = coord[1];
        result_next.point_z = coord[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctrl_end.valid && ctrl_end.ok && !over;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_zero_disp_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        start && (in.disparity_value == '0) |-> ##LATENCY !result_valid)
        else $error("zero disparity produced a point");

    a_z_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.point_z <= (DISCARD_LIMIT * 65536)) &&
                         (result.point_z >= -(DISCARD_LIMIT * 65536)))
        else $error("point beyond discard limit emitted");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en && (cfg_index == REG_Q_R3C23) |=> q_reg[REG_Q_R3C23] == $past(cfg_data))
        else $error("configuration write lost");

endmodule
